// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker of the collision engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define APCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define APCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/apce_pkg.sv =====
// Package of types, codes and constants for the rectangle collision engine.
`timescale 1ns / 1ps

package apce_pkg;

    // Default table and counter sizes.
    localparam int DEF_MAX_TARGETS = 32;
    localparam int DEF_MAX_SHOTS   = 256;

    // At most this many hits are reported for one bullet.
    localparam int MAX_RESULTS = 32;
    localparam int HIT_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Field widths.
    localparam int POS_W      = 16;
    localparam int SIZE_W     = 12;
    localparam int EXT_W      = POS_W + 2;
    localparam int SHOT_IDX_W = 8;
    localparam int TGT_IDX_W  = 5;
    localparam int CFG_IDX_W  = 3;

    // Request modes.
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHOT_WIDTH    = 3'd0,
        CFG_SHOT_HEIGHT   = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3
    } cfg_idx_t;

    // Engine states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_FLUSH = 2'd2
    } state_t;

    // Rectangle sizes as held in the configuration registers.
    typedef struct packed {
        logic [SIZE_W-1:0] shot_width;
        logic [SIZE_W-1:0] shot_height;
        logic [SIZE_W-1:0] target_width;
        logic [SIZE_W-1:0] target_height;
    } cfg_t;

    // One stored enemy corner.
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } tgt_entry_t;

    // Write request from the engine to the target memory.
    typedef struct packed {
        logic       en;
        tgt_entry_t data;
    } tgt_wr_t;

endpackage

// ===== sv/apce_cfg_regs.sv =====
// Configuration registers holding the bullet and enemy rectangle sizes.
`timescale 1ns / 1ps

module apce_cfg_regs import apce_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [SIZE_W-1:0]    cfg_wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes leave everything unchanged.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_wr_index))
                CFG_SHOT_WIDTH:    cfg_next.shot_width    = cfg_wr_data;
                CFG_SHOT_HEIGHT:   cfg_next.shot_height   = cfg_wr_data;
                CFG_TARGET_WIDTH:  cfg_next.target_width  = cfg_wr_data;
                CFG_TARGET_HEIGHT: cfg_next.target_height = cfg_wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/apce_tgt_mem.sv =====
// Synchronous memory of enemy corners with one write and one registered read port.
`timescale 1ns / 1ps

module apce_tgt_mem import apce_pkg::*; #(
    parameter int MAX_TARGETS = DEF_MAX_TARGETS,
    parameter int ADDR_W      = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
    input  logic              aclk,
    input  tgt_wr_t           wr,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output tgt_entry_t        rd_data
);

    tgt_entry_t mem [MAX_TARGETS];
    tgt_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/apce_engine.sv =====
// Request decoder, table scan sequencer, overlap test and result register.
`timescale 1ns / 1ps

module apce_engine import apce_pkg::*; #(
    parameter int MAX_TARGETS = DEF_MAX_TARGETS,
    parameter int MAX_SHOTS   = DEF_MAX_SHOTS,
    parameter int ADDR_W      = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_mode,
    input  logic signed [POS_W-1:0] s_pos_x,
    input  logic signed [POS_W-1:0] s_pos_y,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SHOT_IDX_W-1:0]   m_shot_index,
    output logic [TGT_IDX_W-1:0]    m_target_index,
    output logic                    m_last_hit,
    output tgt_wr_t                 mem_wr,
    output logic [ADDR_W-1:0]       mem_wr_addr,
    output logic                    mem_rd_en,
    output logic [ADDR_W-1:0]       mem_rd_addr,
    input  tgt_entry_t              mem_rd_data
);

    localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
    localparam int SHOT_W = $clog2(MAX_SHOTS);

    state_t state_reg, state_next;

    // Control registers.
    logic [CNT_W-1:0]     tcount_reg, tcount_next;
    logic [SHOT_W-1:0]    shot_cnt_reg, shot_cnt_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [HIT_CNT_W-1:0] nhit_reg, nhit_next;
    logic                 stop_reg, stop_next;
    logic                 m_valid_reg, m_valid_next;

    // Payload registers.
    logic [SHOT_W-1:0]        qshot_reg;
    logic signed [EXT_W-1:0]  bx_reg, by_reg, bx_r_reg, by_b_reg;
    logic [ADDR_W-1:0]        chk_idx_reg, pend_idx_reg;
    logic [SHOT_IDX_W-1:0]    m_shot_index_reg;
    logic [TGT_IDX_W-1:0]     m_target_index_reg;
    logic                     m_last_hit_reg;

    // Decoded state flags.
    logic in_idle, in_scan, in_flush;

    logic                    in_acc, out_free, issue, chk_live, hit, take, scan_end;
    logic                    out_load, out_last;
    logic signed [EXT_W-1:0] in_x, in_y, ex, ey, ex_r, ey_b;
    logic [SHOT_W+SHOT_IDX_W-1:0] shot_ext;
    logic [ADDR_W+TGT_IDX_W-1:0]  idx_ext;

    // State decode.
    always_comb begin
        in_idle  = 1'b0;
        in_scan  = 1'b0;
        in_flush = 1'b0;
        case (state_reg)
            ST_IDLE:  in_idle  = 1'b1;
            ST_SCAN:  in_scan  = 1'b1;
            ST_FLUSH: in_flush = 1'b1;
            default:  in_idle  = 1'b1;
        endcase
    end

    assign s_ready  = in_idle;
    assign in_acc   = s_valid && in_idle;
    assign out_free = !m_valid_reg || m_ready;

    // Scan issue: one table entry per cycle while the result side can move.
    assign issue    = in_scan && out_free && !stop_reg && (rd_idx_reg < tcount_reg);
    assign chk_live = chk_valid_reg && !stop_reg;
    assign scan_end = in_scan && (stop_reg || (rd_idx_reg == tcount_reg)) && !chk_live;

    // Overlap test; touching edges count as a hit.
    assign ex   = EXT_W'(mem_rd_data.x);
    assign ey   = EXT_W'(mem_rd_data.y);
    assign ex_r = ex + $signed({{(EXT_W-SIZE_W){1'b0}}, cfg.target_width});
    assign ey_b = ey + $signed({{(EXT_W-SIZE_W){1'b0}}, cfg.target_height});
    assign hit  = chk_live && !((bx_r_reg < ex) || (ex_r < bx_reg) ||
                                (by_b_reg < ey) || (ey_b < by_reg));
    assign take = hit && out_free;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_mode == MODE_QUERY)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result register loading: a held hit leaves when a newer one arrives,
    // and the final held hit leaves marked as last once the scan is over.
    always_comb begin
        out_load = 1'b0;
        out_last = 1'b0;
        case (state_reg)
            ST_SCAN: begin
                out_load = take && pend_valid_reg;
            end
            ST_FLUSH: begin
                out_load = pend_valid_reg && out_free;
                out_last = 1'b1;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Memory access; writes happen only when idle, so no read can overlap them.
    assign in_x = EXT_W'(s_pos_x);
    assign in_y = EXT_W'(s_pos_y);

    always_comb begin
        mem_wr.en     = in_acc && (s_mode == MODE_APPEND) &&
                        (tcount_reg < CNT_W'(MAX_TARGETS));
        mem_wr.data.x = s_pos_x;
        mem_wr.data.y = s_pos_y;
    end

    assign mem_wr_addr = tcount_reg[ADDR_W-1:0];
    assign mem_rd_en   = issue;
    assign mem_rd_addr = rd_idx_reg[ADDR_W-1:0];

    // Control register updates.
    always_comb begin
        tcount_next     = tcount_reg;
        shot_cnt_next   = shot_cnt_reg;
        rd_idx_next     = rd_idx_reg;
        chk_valid_next  = chk_valid_reg;
        pend_valid_next = pend_valid_reg;
        nhit_next       = nhit_reg;
        stop_next       = stop_reg;

        if (in_acc) begin
            case (mode_t'(s_mode))
                MODE_CLEAR: begin
                    tcount_next   = '0;
                    shot_cnt_next = '0;
                end
                MODE_APPEND: begin
                    if (mem_wr.en) begin
                        tcount_next = tcount_reg + CNT_W'(1);
                    end
                end
                MODE_QUERY: begin
                    if (shot_cnt_reg < SHOT_W'(MAX_SHOTS - 1)) begin
                        shot_cnt_next = shot_cnt_reg + SHOT_W'(1);
                    end
                    rd_idx_next     = '0;
                    chk_valid_next  = 1'b0;
                    pend_valid_next = 1'b0;
                    nhit_next       = '0;
                    stop_next       = 1'b0;
                end
                default: begin
                    tcount_next = tcount_reg;
                end
            endcase
        end

        if (in_scan && out_free) begin
            chk_valid_next = issue;
            if (issue) begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (take) begin
                pend_valid_next = 1'b1;
                nhit_next       = nhit_reg + HIT_CNT_W'(1);
                if (nhit_reg + HIT_CNT_W'(1) == HIT_CNT_W'(MAX_RESULTS)) begin
                    stop_next = 1'b1;
                end
            end
        end

        if (in_flush && out_load) begin
            pend_valid_next = 1'b0;
        end
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tcount_reg     <= '0;
            shot_cnt_reg   <= '0;
            rd_idx_reg     <= '0;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            nhit_reg       <= '0;
            stop_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tcount_reg     <= tcount_next;
            shot_cnt_reg   <= shot_cnt_next;
            rd_idx_reg     <= rd_idx_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            nhit_reg       <= nhit_next;
            stop_reg       <= stop_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Bullet edges are captured when the query is accepted.
    always_ff @(posedge aclk) begin
        if (in_acc && (s_mode == MODE_QUERY)) begin
            qshot_reg <= shot_cnt_reg;
            bx_reg    <= in_x;
            by_reg    <= in_y;
            bx_r_reg  <= in_x + $signed({{(EXT_W-SIZE_W){1'b0}}, cfg.shot_width});
            by_b_reg  <= in_y + $signed({{(EXT_W-SIZE_W){1'b0}}, cfg.shot_height});
        end
    end

    // Index pipeline: read index, then held hit.
    always_ff @(posedge aclk) begin
        if (issue) begin
            chk_idx_reg <= rd_idx_reg[ADDR_W-1:0];
        end
        if (in_scan && take) begin
            pend_idx_reg <= chk_idx_reg;
        end
    end

    // Result payload, masked to the port widths.
    assign shot_ext = {{SHOT_IDX_W{1'b0}}, qshot_reg};
    assign idx_ext  = {{TGT_IDX_W{1'b0}}, pend_idx_reg};

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_shot_index_reg   <= shot_ext[SHOT_IDX_W-1:0];
            m_target_index_reg <= idx_ext[TGT_IDX_W-1:0];
            m_last_hit_reg     <= out_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_shot_index   = m_shot_index_reg;
    assign m_target_index = m_target_index_reg;
    assign m_last_hit     = m_last_hit_reg;

endmodule

// ===== sv/aabb_pair_collision_engine_top.sv =====
// Top level of the bullet against enemy rectangle collision engine.
//
//  Channel  Direction  Handshake               Carries
//  s_       in         s_valid / s_ready       mode, pos_x, pos_y
//  m_       out        m_valid / m_ready       shot_index, target_index, last_hit
//  cfg_     in         cfg_wr_en (no wait)     register index and size value
//
// Clear, append and unused-mode requests do not hold the input off.
// A query holds the input off from its acceptance until the scan has ended and
// the last held hit has been loaded, while results are taken at once: the enemy
// memory has a single read port and is scanned one entry per cycle, and each
// hit is held in a register so that the last one can be marked.
// A stalled result output freezes the scan; no request is taken during a scan.
// Reset is synchronous and active low; the table is empty after reset.
`timescale 1ns / 1ps

module aabb_pair_collision_engine_top import apce_pkg::*; #(
    parameter int MAX_TARGETS = DEF_MAX_TARGETS,
    parameter int MAX_SHOTS   = DEF_MAX_SHOTS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [SIZE_W-1:0]       cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_mode,
    input  logic signed [POS_W-1:0] s_pos_x,
    input  logic signed [POS_W-1:0] s_pos_y,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SHOT_IDX_W-1:0]   m_shot_index,
    output logic [TGT_IDX_W-1:0]    m_target_index,
    output logic                    m_last_hit
);

    localparam int ADDR_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

    cfg_t              cfg;
    tgt_wr_t           mem_wr;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    tgt_entry_t        mem_rd_data;

    // Rectangle size registers.
    apce_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Enemy corner table.
    apce_tgt_mem #(
        .MAX_TARGETS (MAX_TARGETS),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .wr_addr (mem_wr_addr),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Request handling and table scan.
    apce_engine #(
        .MAX_TARGETS (MAX_TARGETS),
        .MAX_SHOTS   (MAX_SHOTS),
        .ADDR_W      (ADDR_W)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_shot_index   (m_shot_index),
        .m_target_index (m_target_index),
        .m_last_hit     (m_last_hit),
        .mem_wr         (mem_wr),
        .mem_wr_addr    (mem_wr_addr),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

endmodule

// ===== sv/apce_checker.sv =====
// Port-level checker for the collision engine, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module apce_checker import apce_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [1:0]            s_mode,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [SHOT_IDX_W-1:0] m_shot_index,
    input logic [TGT_IDX_W-1:0]  m_target_index,
    input logic                  m_last_hit
);

    // A stalled result keeps its contents.
    `APCE_ASSERT_NXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_shot_index) && $stable(m_target_index) && $stable(m_last_hit), "stalled result changed")

    // A query starts a scan, so no further request is taken in the next cycle.
    `APCE_ASSERT_NXT(a_query_blocks, s_valid && s_ready && (s_mode == MODE_QUERY), !s_ready, "request taken right after a query")

    // Requests other than queries complete in their own cycle.
    `APCE_ASSERT_NXT(a_short_requests, s_valid && s_ready && (s_mode != MODE_QUERY), s_ready, "non-query request blocked the input")

    // While a non-final hit is shown the bullet still has hits pending.
    `APCE_ASSERT_IMP(a_pending_hits, m_valid && !m_last_hit, !s_ready, "input open while bullet results remain")

endmodule

bind aabb_pair_collision_engine_top apce_checker u_apce_checker (.*);
